// ----- rtl/md5sh_pkg.sv -----
// Package for the streaming MD5 hash core: request/response payload types,
// working-state types, round constants and small round helper functions.
// No dependencies.
package md5sh_pkg;

   typedef enum logic {
      ACT_ABSORB = 1'b0,
      ACT_FINISH = 1'b1
   } md5sh_action_type;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } md5sh_req_type;

   typedef struct packed {
      logic [63:0] digest_low;
      logic [63:0] digest_high;
   } md5sh_rsp_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5sh_words_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic [5:0] round;
   } md5sh_rnd_ctrl_type;

   localparam md5sh_words_type INIT_WORDS = '{
      a: 32'h67452301, b: 32'hefcdab89, c: 32'h98badcfe, d: 32'h10325476};

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [5:0] PAD_FILL  = 6'd56;
   localparam logic [5:0] LAST_POS  = 6'd63;
   localparam logic [5:0] LAST_RND  = 6'd63;
   localparam logic [2:0] LAST_LEN  = 3'd7;

   localparam logic [31:0] ROUND_ADD [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Left-rotate amount for a round: row by stage, column by round mod 4.
   function automatic logic [4:0] rot_amount(input logic [5:0] round);
      logic [3:0] sel;
      logic [4:0] amt;
      begin
         sel = {round[5:4], round[1:0]};
         case (sel)
            4'h0: amt = 5'd7;   4'h1: amt = 5'd12;
            4'h2: amt = 5'd17;  4'h3: amt = 5'd22;
            4'h4: amt = 5'd5;   4'h5: amt = 5'd9;
            4'h6: amt = 5'd14;  4'h7: amt = 5'd20;
            4'h8: amt = 5'd4;   4'h9: amt = 5'd11;
            4'ha: amt = 5'd16;  4'hb: amt = 5'd23;
            4'hc: amt = 5'd6;   4'hd: amt = 5'd10;
            4'he: amt = 5'd15;  default: amt = 5'd21;
         endcase
         return amt;
      end
   endfunction

   // Message word used by a round; all arithmetic wraps mod 16.
   function automatic logic [3:0] word_index(input logic [5:0] round);
      logic [3:0] r;
      logic [3:0] idx;
      begin
         r = round[3:0];
         case (round[5:4])
            2'd0:    idx = r;
            2'd1:    idx = r * 4'd5 + 4'd1;
            2'd2:    idx = r * 4'd3 + 4'd5;
            default: idx = r * 4'd7;
         endcase
         return idx;
      end
   endfunction

endpackage

// ----- rtl/md5sh_block_store.sv -----
// 64-byte message block store: byte-wide writes, one 32-bit word read.
// Depends on md5sh_pkg.
module md5sh_block_store (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [5:0]  wr_pos,
   input  logic [7:0]  wr_byte,
   input  logic [3:0]  rd_index,
   output logic [31:0] rd_word
);
   import md5sh_pkg::*;

   logic [31:0] words_ff [16];

   // Bytes land little-endian inside each word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

   assign rd_word = words_ff[rd_index];

endmodule

// ----- rtl/md5sh_round_unit.sv -----
// Shared MD5 round unit: holds the four working words and applies one round
// per step. Depends on md5sh_pkg.
module md5sh_round_unit (
   input  logic                         clock,
   input  md5sh_pkg::md5sh_rnd_ctrl_type ctrl,
   input  md5sh_pkg::md5sh_words_type    seed,
   input  logic [31:0]                  msg_word,
   output md5sh_pkg::md5sh_words_type    work
);
   import md5sh_pkg::*;

   md5sh_words_type work_ff;
   md5sh_words_type work_in;
   logic [31:0]     f_val;
   logic [31:0]     t_sum;
   logic [63:0]     rot_wide;

   always_comb begin
      case (ctrl.round[5:4])
         2'd0:    f_val = (work_ff.b & work_ff.c) | (~work_ff.b & work_ff.d);
         2'd1:    f_val = (work_ff.d & work_ff.b) | (~work_ff.d & work_ff.c);
         2'd2:    f_val = work_ff.b ^ work_ff.c ^ work_ff.d;
         default: f_val = work_ff.c ^ (work_ff.b | ~work_ff.d);
      endcase
      t_sum    = work_ff.a + f_val + ROUND_ADD[ctrl.round] + msg_word;
      rot_wide = {t_sum, t_sum} << rot_amount(ctrl.round);

      work_in = work_ff;
      if (ctrl.load) begin
         work_in = seed;
      end else if (ctrl.step) begin
         work_in.a = work_ff.d;
         work_in.d = work_ff.c;
         work_in.c = work_ff.b;
         work_in.b = work_ff.b + rot_wide[63:32];
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work = work_ff;

endmodule

// ----- rtl/md5sh_sequencer.sv -----
// Sequencer for the MD5 core: byte gathering, padding, round stepping,
// chaining update and digest output register. Depends on md5sh_pkg.
module md5sh_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  md5sh_pkg::md5sh_req_type      req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output md5sh_pkg::md5sh_rsp_type      rsp_data,
   output logic                          put_en,
   output logic [5:0]                    put_pos,
   output logic [7:0]                    put_byte,
   output md5sh_pkg::md5sh_rnd_ctrl_type rnd_ctrl,
   output md5sh_pkg::md5sh_words_type    chain,
   input  md5sh_pkg::md5sh_words_type    work
);
   import md5sh_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PAD  = 5'b00010,
      S_COMP = 5'b00100,
      S_FOLD = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [5:0]      fill_ff, fill_in;
   logic [60:0]     msg_ff, msg_in;
   logic [5:0]      round_ff, round_in;
   logic [2:0]      len_cnt_ff, len_cnt_in;
   logic            len_phase_ff, len_phase_in;
   logic            len_done_ff, len_done_in;
   logic            finishing_ff, finishing_in;
   md5sh_words_type chain_ff, chain_in;
   logic            rsp_valid_ff, rsp_valid_in;
   md5sh_rsp_type   rsp_data_ff, rsp_data_in;
   logic [63:0]     bit_len;
   logic            req_take;

   assign bit_len   = {msg_ff, 3'b000};
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      msg_in       = msg_ff;
      round_in     = round_ff;
      len_cnt_in   = len_cnt_ff;
      len_phase_in = len_phase_ff;
      len_done_in  = len_done_ff;
      finishing_in = finishing_ff;
      chain_in     = chain_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      put_en       = 1'b0;
      put_byte     = 8'h00;
      rnd_ctrl     = '{load: 1'b0, step: 1'b0, round: round_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               put_en = 1'b1;
               if (req_data.action == ACT_FINISH) begin
                  put_byte     = PAD_BYTE;
                  finishing_in = 1'b1;
                  len_phase_in = 1'b0;
                  len_cnt_in   = 3'd0;
                  len_done_in  = 1'b0;
                  state_in     = S_PAD;
               end else begin
                  put_byte = req_data.data_byte;
                  msg_in   = msg_ff + 61'd1;
               end
            end
         end
         S_PAD: begin
            put_en = 1'b1;
            if (!len_phase_ff && fill_ff != PAD_FILL) begin
               put_byte = 8'h00;
            end else begin
               put_byte     = bit_len[{len_cnt_ff, 3'b000} +: 8];
               len_phase_in = 1'b1;
               len_cnt_in   = len_cnt_ff + 3'd1;
               if (len_cnt_ff == LAST_LEN) begin
                  len_done_in = 1'b1;
               end
            end
         end
         S_COMP: begin
            rnd_ctrl.step = 1'b1;
            round_in      = round_ff + 6'd1;
            if (round_ff == LAST_RND) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            chain_in.a = chain_ff.a + work.a;
            chain_in.b = chain_ff.b + work.b;
            chain_in.c = chain_ff.c + work.c;
            chain_in.d = chain_ff.d + work.d;
            if (!finishing_ff) begin
               state_in = S_IDLE;
            end else if (len_done_ff) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_PAD;
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.digest_low  = {chain_ff.b, chain_ff.a};
               rsp_data_in.digest_high = {chain_ff.d, chain_ff.c};
               rsp_valid_in = 1'b1;
               chain_in     = INIT_WORDS;
               fill_in      = 6'd0;
               msg_in       = 61'd0;
               finishing_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // a full block starts a compression
      if (put_en) begin
         if (fill_ff == LAST_POS) begin
            fill_in       = 6'd0;
            round_in      = 6'd0;
            rnd_ctrl.load = 1'b1;
            state_in      = S_COMP;
         end else begin
            fill_in = fill_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= 6'd0;
         msg_ff       <= 61'd0;
         round_ff     <= 6'd0;
         len_cnt_ff   <= 3'd0;
         len_phase_ff <= 1'b0;
         len_done_ff  <= 1'b0;
         finishing_ff <= 1'b0;
         chain_ff     <= INIT_WORDS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         msg_ff       <= msg_in;
         round_ff     <= round_in;
         len_cnt_ff   <= len_cnt_in;
         len_phase_ff <= len_phase_in;
         len_done_ff  <= len_done_in;
         finishing_ff <= finishing_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign put_pos   = fill_ff;
   assign chain     = chain_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/md5_stream_hash_core.sv -----
// Streaming MD5 hash core, top level: ties the sequencer, the block store
// and the shared round unit. Depends on md5sh_pkg and the md5sh_* modules.
//
// Usage:
//   Requests arrive on req_* (valid/stall). Each request carries an action:
//   absorb appends data_byte to the message, finish pads the message, runs
//   the remaining compressions and posts the 128-bit digest on rsp_*.
//   An absorb request produces no response; a finish produces exactly one.
// Sequencing:
//   An absorb is taken without a stall, except the byte that fills a 64-byte
//   block: req_stall then stays high while 64 rounds run through the single
//   round unit and the chaining update follows.
//   A finish walks the padding one byte per cycle, pausing while a
//   compression runs (one or two), through the same byte path (9 to 72 bytes),
//   and the digest then goes into the output register.
// Reset:
//   reset (synchronous, active high) restores the MD5 initial chaining
//   words, empties the block and the length count and drops any response.
// Back-pressure:
//   The digest sits in an output register; new requests are taken while
//   it waits. A following finish holds in its last step until the register
//   is taken. rsp_data does not change while rsp_valid is high and stalled.
module md5_stream_hash_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  md5sh_pkg::md5sh_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output md5sh_pkg::md5sh_rsp_type rsp_data
);
   import md5sh_pkg::*;

   logic               put_en;
   logic [5:0]         put_pos;
   logic [7:0]         put_byte;
   logic [31:0]        msg_word;
   md5sh_rnd_ctrl_type rnd_ctrl;
   md5sh_words_type    chain;
   md5sh_words_type    work;

   // control: gather bytes, pad, step the rounds, fold and emit
   md5sh_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .put_en    (put_en),
      .put_pos   (put_pos),
      .put_byte  (put_byte),
      .rnd_ctrl  (rnd_ctrl),
      .chain     (chain),
      .work      (work)
   );

   // message block, read at the word the current round needs
   md5sh_block_store u_store (
      .clock    (clock),
      .wr_en    (put_en),
      .wr_pos   (put_pos),
      .wr_byte  (put_byte),
      .rd_index (word_index(rnd_ctrl.round)),
      .rd_word  (msg_word)
   );

   // one MD5 round per cycle, seeded from the chaining words
   md5sh_round_unit u_round (
      .clock    (clock),
      .ctrl     (rnd_ctrl),
      .seed     (chain),
      .msg_word (msg_word),
      .work     (work)
   );

endmodule
